// ----- design/pattern_byte_swap_stream_core_assert.svh -----
// Assertion macros shared by the byte swap stream RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef PATTERN_BYTE_SWAP_STREAM_CORE_ASSERT_SVH
`define PATTERN_BYTE_SWAP_STREAM_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PBSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbss check failed");

// next-cycle implication, disabled while in reset
`define PBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbss check failed");

`endif

// ----- design/pbss_pkg.sv -----
// Shared types and constants for the pattern byte swap stream.
// No dependencies; used by all design modules.
package pbss_pkg;

  localparam int MAX_SEGMENTS_DEF = 4;
  localparam int SEG_REGS         = 4;
  localparam int BYTE_W           = 8;
  localparam int GROUP_CAP        = 4;
  localparam int POS_W            = 2;
  localparam int SEG_LEN_W        = 31;
  localparam int SEG_CNT_W        = 4;
  localparam int COUNT_REG_W      = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int Q_DEPTH          = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_0     = 3'd1;

  // one output burst: bytes in emit order, index of the final byte
  typedef struct packed {
    logic [GROUP_CAP-1:0][BYTE_W-1:0] bytes;
    logic [POS_W-1:0]                 last_pos;
    logic                             last;
  } grp_t;

endpackage

// ----- design/pbss_swap_core.sv -----
// Group collection and segment tracking for the byte swap stream.
// Depends on pbss_pkg and the assertion macro header.
`include "pattern_byte_swap_stream_core_assert.svh"

module pbss_swap_core #(
  parameter int MAX_SEGMENTS = pbss_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             accept,
  input  logic [pbss_pkg::BYTE_W-1:0]                      in_byte,
  input  logic                                             in_last,
  input  logic [pbss_pkg::COUNT_REG_W-1:0]                 segment_count,
  input  logic [MAX_SEGMENTS-1:0][pbss_pkg::CFG_DATA_W-1:0] seg_words,
  output logic                                             push,
  output pbss_pkg::grp_t                                   grp
);
  import pbss_pkg::*;

  localparam int SEG_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  logic [GROUP_CAP-1:0][BYTE_W-1:0] held_r;
  logic [POS_W-1:0]                 fill_r, fill_nxt;
  logic [SEG_IDX_W-1:0]             idx_r, idx_nxt;
  logic [SEG_LEN_W-1:0]             done_r, done_nxt;

  logic [SEG_CNT_W-1:0]             cnt_eff;
  logic [SEG_IDX_W-1:0]             idx_eff;
  logic [SEG_CNT_W-1:0]             idx_inc;
  logic [CFG_DATA_W-1:0]            word;
  logic                             quad;
  logic [SEG_LEN_W-1:0]             len;
  logic [POS_W:0]                   fill_new;
  logic [POS_W:0]                   gsize;
  logic                             full_grp;
  logic [SEG_LEN_W-1:0]             done_inc;
  logic [GROUP_CAP-1:0][BYTE_W-1:0] bytes_cur;

  always_comb begin
    if (segment_count == '0) begin
      cnt_eff = SEG_CNT_W'(1);
    end else if ({1'b0, segment_count} > SEG_CNT_W'(MAX_SEGMENTS)) begin
      cnt_eff = SEG_CNT_W'(MAX_SEGMENTS);
    end else begin
      cnt_eff = {1'b0, segment_count};
    end
    idx_eff  = (SEG_CNT_W'(idx_r) >= cnt_eff) ? '0 : idx_r;
    word     = seg_words[idx_eff];
    quad     = word[CFG_DATA_W-1];
    // length bits below the group size are dropped
    len      = {word[SEG_LEN_W-1:2], word[1] & ~quad, 1'b0};
    gsize    = quad ? (POS_W+1)'(4) : (POS_W+1)'(2);
    fill_new = {1'b0, fill_r} + (POS_W+1)'(1);
    full_grp = fill_new >= gsize;
    done_inc = done_r + SEG_LEN_W'(1);
    idx_inc  = SEG_CNT_W'(idx_eff) + SEG_CNT_W'(1);
  end

  always_comb begin
    bytes_cur         = held_r;
    bytes_cur[fill_r] = in_byte;
    grp.last_pos      = fill_r;
    grp.last          = in_last;
    for (int k = 0; k < GROUP_CAP; k++) begin
      grp.bytes[k] = full_grp ? bytes_cur[fill_r - POS_W'(k)] : bytes_cur[k];
    end
    push = accept && (full_grp || in_last);
  end

  always_comb begin
    fill_nxt = fill_r;
    idx_nxt  = idx_r;
    done_nxt = done_r;
    if (accept) begin
      fill_nxt = (full_grp || in_last) ? '0 : fill_new[POS_W-1:0];
      idx_nxt  = idx_eff;
      done_nxt = done_inc;
      if (full_grp && len != '0 && done_inc >= len) begin
        idx_nxt  = (idx_inc >= cnt_eff) ? '0 : idx_inc[SEG_IDX_W-1:0];
        done_nxt = '0;
      end
      if (in_last) begin
        idx_nxt  = '0;
        done_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      idx_r  <= '0;
      done_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r[fill_r] <= in_byte;
    end
  end

  `PBSS_ASSERT_NEXT(a_last_clears_state, clk, rst_n, accept && in_last, {fill_r, idx_r, done_r} == '0)
  `PBSS_ASSERT_NOW(a_push_on_last, clk, rst_n, accept && in_last, push)
  `PBSS_ASSERT_NOW(a_push_needs_accept, clk, rst_n, !accept, !push)

endmodule

// ----- design/pbss_out_queue.sv -----
// Burst queue and byte serializer for the byte swap stream.
// Depends on pbss_pkg and the assertion macro header.
`include "pattern_byte_swap_stream_core_assert.svh"

module pbss_out_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  pbss_pkg::grp_t              grp,
  output logic                        full,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pbss_pkg::BYTE_W-1:0] out_tdata,
  output logic                        out_tlast
);
  import pbss_pkg::*;

  localparam int QPTR_W = $clog2(Q_DEPTH);

  grp_t                mem [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     cnt_r;
  logic [POS_W-1:0]    pos_r;
  grp_t                head;
  logic                pop, pop_entry, empty;

  always_comb begin
    head       = mem[rd_ptr_r];
    empty      = cnt_r == '0;
    full       = cnt_r == (QPTR_W+1)'(Q_DEPTH);
    out_tvalid = !empty;
    out_tdata  = head.bytes[pos_r];
    out_tlast  = head.last && pos_r == head.last_pos;
    pop        = out_tvalid && out_tready;
    pop_entry  = pop && pos_r == head.last_pos;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      pos_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop_entry) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
        pos_r    <= '0;
      end else if (pop) begin
        pos_r    <= pos_r + POS_W'(1);
      end
      if (push && !pop_entry) begin
        cnt_r <= cnt_r + (QPTR_W+1)'(1);
      end else if (!push && pop_entry) begin
        cnt_r <= cnt_r - (QPTR_W+1)'(1);
      end
    end
  end

  `PBSS_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full)
  `PBSS_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= (QPTR_W+1)'(Q_DEPTH))
  `PBSS_ASSERT_NOW(a_pos_in_burst, clk, rst_n, !empty, pos_r <= head.last_pos)

endmodule

// ----- design/pattern_byte_swap_stream_core.sv -----
// Pattern byte swap stream: reorders a byte stream by a repeating table of
// pair or quadruple swap segments. One input byte is taken per cycle; each
// completed group (and the tail group on the last byte) is written as one
// burst into a four-entry queue, which drains one byte per cycle while
// out_tready is high. The input is stalled only while that queue is full, so
// sustained throughput is one byte per cycle in and out; a group's first output
// byte is presented once its burst is registered in the queue and earlier bursts
// have drained. Depends on pbss_pkg, pbss_swap_core and pbss_out_queue.
module pattern_byte_swap_stream_core #(
  parameter int MAX_SEGMENTS = pbss_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pbss_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pbss_pkg::BYTE_W-1:0]    out_tdata,  // [7:0] out_byte
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [pbss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pbss_pkg::*;

  logic [COUNT_REG_W-1:0]                   segment_count_r;
  logic [MAX_SEGMENTS-1:0][CFG_DATA_W-1:0]  seg_words_r;
  logic                                     accept, push, full;
  grp_t                                     grp;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_count_r <= COUNT_REG_W'(1);
    end else if (cfg_we && cfg_index == REG_SEGMENT_COUNT) begin
      segment_count_r <= cfg_wdata[COUNT_REG_W-1:0];
    end
  end

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_seg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        seg_words_r[i] <= '0;
      end else if (i < SEG_REGS && cfg_we &&
                   cfg_index == REG_SEGMENT_0 + CFG_IDX_W'(i)) begin
        seg_words_r[i] <= cfg_wdata;
      end
    end
  end

  pbss_swap_core #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_tdata),
    .in_last       (in_tlast),
    .segment_count (segment_count_r),
    .seg_words     (seg_words_r),
    .push          (push),
    .grp           (grp)
  );

  pbss_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .grp        (grp),
    .full       (full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
